// ----- src/ttim_pkg.sv -----
// Package for the tensor transpose index map: widths, register indexes and
// the saturating arithmetic used by the stride setup and the index pipeline.
// No dependencies.
package ttim_pkg;

    localparam int DIMS       = 4;
    localparam int IDX_W      = 32;
    localparam int SIZE_W     = 16;
    localparam int RANK_W     = 3;
    localparam int DIM_W      = 2;
    localparam int PERM_W     = DIMS * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STR_W      = IDX_W + 1;
    localparam int QB         = SIZE_W;
    localparam int SH_W       = STR_W + QB - 1;
    localparam int PROD_W     = STR_W + SIZE_W;
    localparam int NSTEP      = DIMS * QB;
    localparam int SETTLE     = DIMS + 3;
    localparam int SETTLE_W   = $clog2(SETTLE + 1);
    localparam int TDATA_W    = ((IDX_W + 7) / 8) * 8;
    localparam int SKID_DEPTH = 2;
    localparam int SKID_CNT_W = 2;

    localparam logic [STR_W-1:0] CAP = {1'b1, {IDX_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERM  = 3'd5;

    localparam logic [RANK_W-1:0] RANK_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1;
    localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

    // Product of a stride and a size, saturated at 2^IDX_W.
    function automatic logic [STR_W-1:0] sat_mul(input logic [STR_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return (p >= PROD_W'(CAP)) ? CAP : p[STR_W-1:0];
    endfunction

    // Accumulate a partial term, saturating at 2^IDX_W - 1.
    function automatic logic [IDX_W-1:0] sat_add(input logic [IDX_W-1:0] acc,
                                                 input logic [SH_W-1:0] add);
        logic [SH_W:0] s;
        s = (SH_W + 1)'(acc) + (SH_W + 1)'(add);
        return (s >= (SH_W + 1)'(CAP)) ? {IDX_W{1'b1}} : s[IDX_W-1:0];
    endfunction

endpackage

// ----- src/tensor_transpose_index_map.sv -----
// Top level of the tensor transpose index map: configuration registers,
// stride setup, the restoring-division pipeline and the output skid buffer.
// Depends on ttim_pkg.
//
// Usage: the slave stream carries one output index per transaction in
// s_tdata; the master stream returns the matching source index in m_tdata
// and the out-of-range flag in m_tuser. One transaction is accepted per
// cycle and one result leaves per cycle, unless the receiver stalls, the
// skid buffer is full or the strides are being rebuilt. A result reaches
// m_tvalid through 64 restoring division steps, 16 per dimension for four
// dimensions, each step one compare-subtract of the remainder against a
// shifted output stride, and is then registered into the output skid buffer.
// The configuration port writes a register at every clock edge with
// cfg_wr_en high. Strides and the element count are rebuilt in registers
// after each write, one saturating multiply per cycle; s_tready stays low
// after a write and after reset until settle_reg is zero, for that reason.
// Reset restores rank 4, all sizes 1 and the identity permutation.
// When the receiver stalls, results collect in a two-entry skid buffer;
// once it is full the whole pipeline holds and s_tready drops, so nothing
// is lost or repeated.
module tensor_transpose_index_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ttim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttim_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ttim_pkg::TDATA_W-1:0]    s_tdata,  // [31:0] output_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ttim_pkg::TDATA_W-1:0]    m_tdata,  // [31:0] source_index
    output logic                            m_tuser   // [0] out_of_range
);
    import ttim_pkg::*;

    logic [RANK_W-1:0]   rank_reg;
    logic [SIZE_W-1:0]   size_reg [DIMS];
    logic [PERM_W-1:0]   perm_reg;
    logic [SETTLE_W-1:0] settle_reg;

    logic [RANK_W-1:0]   rank_c;
    logic [DIM_W-1:0]    perm_c [DIMS];
    logic [SIZE_W-1:0]   sz_c   [DIMS];

    logic [DIM_W-1:0]    dperm_reg [DIMS];
    logic [SIZE_W-1:0]   dsz_reg   [DIMS];
    logic [SIZE_W-1:0]   szo_reg   [DIMS];
    logic [STR_W-1:0]    in_s_reg  [DIMS];
    logic [STR_W-1:0]    ou_s_reg  [DIMS];
    logic [STR_W-1:0]    ins_reg   [DIMS];
    logic [STR_W-1:0]    count_reg;

    logic                adv;
    logic [IDX_W-1:0]    rem_reg  [NSTEP+1];
    logic [IDX_W-1:0]    rem_next [NSTEP+1];
    logic [IDX_W-1:0]    acc_reg  [NSTEP+1];
    logic [IDX_W-1:0]    acc_next [NSTEP+1];
    logic [SH_W-1:0]     add_reg  [NSTEP+1];
    logic [SH_W-1:0]     add_next [NSTEP+1];
    logic                oor_reg  [NSTEP+1];
    logic                oor_next [NSTEP+1];
    logic                vld_reg  [NSTEP+1];
    logic                vld_next [NSTEP+1];

    logic [IDX_W-1:0]      skid_src_reg [SKID_DEPTH];
    logic                  skid_oor_reg [SKID_DEPTH];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [SKID_CNT_W-1:0] skid_cnt_reg;
    logic                  push;
    logic                  pop;
    logic [IDX_W-1:0]      final_src;

    // Configuration registers and the settle counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg   <= RANK_RESET;
            perm_reg   <= PERM_RESET;
            settle_reg <= SETTLE_W'(SETTLE);
            for (int d = 0; d < DIMS; d++)
            begin
                size_reg[d] <= SIZE_RESET;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                settle_reg <= SETTLE_W'(SETTLE);
                unique case (cfg_index) inside
                    REG_RANK:
                    begin
                        rank_reg <= cfg_data[RANK_W-1:0];
                    end
                    REG_SIZE0, REG_SIZE1, REG_SIZE2, REG_SIZE3:
                    begin
                        size_reg[DIM_W'(cfg_index - REG_SIZE0)] <= cfg_data[SIZE_W-1:0];
                    end
                    REG_PERM:
                    begin
                        perm_reg <= cfg_data[PERM_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    // Rank clamp, permutation clamp and padding of unused dimensions.
    always_comb
    begin
        if (rank_reg == '0)
        begin
            rank_c = RANK_W'(1);
        end
        else if (rank_reg > RANK_W'(DIMS))
        begin
            rank_c = RANK_W'(DIMS);
        end
        else
        begin
            rank_c = rank_reg;
        end
        for (int i = 0; i < DIMS; i++)
        begin
            if (RANK_W'(i) < rank_c)
            begin
                if (RANK_W'(perm_reg[DIM_W*i +: DIM_W]) >= rank_c)
                begin
                    perm_c[i] = DIM_W'(rank_c - RANK_W'(1));
                end
                else
                begin
                    perm_c[i] = perm_reg[DIM_W*i +: DIM_W];
                end
                sz_c[i] = size_reg[i];
            end
            else
            begin
                perm_c[i] = DIM_W'(i);
                sz_c[i]   = SIZE_W'(1);
            end
        end
    end

    // Stride setup: one saturating multiply per register per cycle.
    always_ff @(posedge clk)
    begin
        count_reg <= sat_mul(ou_s_reg[0], szo_reg[0]);
        for (int i = 0; i < DIMS; i++)
        begin
            dperm_reg[i] <= perm_c[i];
            dsz_reg[i]   <= sz_c[i];
            szo_reg[i]   <= dsz_reg[dperm_reg[i]];
            ins_reg[i]   <= in_s_reg[dperm_reg[i]];
            if (i == DIMS - 1)
            begin
                in_s_reg[i] <= STR_W'(1);
                ou_s_reg[i] <= STR_W'(1);
            end
            else
            begin
                in_s_reg[i] <= sat_mul(in_s_reg[i+1], dsz_reg[i+1]);
                ou_s_reg[i] <= sat_mul(ou_s_reg[i+1], szo_reg[i+1]);
            end
        end
    end

    assign adv      = (skid_cnt_reg != SKID_CNT_W'(SKID_DEPTH));
    assign s_tready = adv && (settle_reg == '0);

    always_comb
    begin
        rem_next[0] = s_tdata[IDX_W-1:0];
        acc_next[0] = '0;
        add_next[0] = '0;
        oor_next[0] = ({1'b0, s_tdata[IDX_W-1:0]} >= count_reg);
        vld_next[0] = s_tvalid && (settle_reg == '0);
    end

    // One restoring division step per stage; the term chosen by a quotient
    // bit is added into the source index one stage later.
    for (genvar g = 0; g < NSTEP; g++)
    begin : g_step
        localparam int D = g / QB;
        localparam int K = QB - 1 - (g % QB);
        logic [SH_W-1:0] div_sh;
        logic            ge;

        always_comb
        begin
            div_sh        = SH_W'(ou_s_reg[D]) << K;
            ge            = (SH_W'(rem_reg[g]) >= div_sh);
            rem_next[g+1] = ge ? (rem_reg[g] - div_sh[IDX_W-1:0]) : rem_reg[g];
            add_next[g+1] = ge ? (SH_W'(ins_reg[D]) << K) : '0;
            acc_next[g+1] = sat_add(acc_reg[g], add_reg[g]);
            oor_next[g+1] = oor_reg[g];
            vld_next[g+1] = vld_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NSTEP; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s <= NSTEP; s++)
            begin
                vld_reg[s] <= vld_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= NSTEP; s++)
            begin
                rem_reg[s] <= rem_next[s];
                acc_reg[s] <= acc_next[s];
                add_reg[s] <= add_next[s];
                oor_reg[s] <= oor_next[s];
            end
        end
    end

    // Output skid buffer.
    assign final_src = oor_reg[NSTEP] ? '0 : sat_add(acc_reg[NSTEP], add_reg[NSTEP]);
    assign push      = adv && vld_reg[NSTEP];
    assign pop       = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            skid_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                skid_cnt_reg <= skid_cnt_reg + SKID_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                skid_cnt_reg <= skid_cnt_reg - SKID_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            skid_src_reg[wr_ptr_reg] <= final_src;
            skid_oor_reg[wr_ptr_reg] <= oor_reg[NSTEP];
        end
    end

    assign m_tvalid = (skid_cnt_reg != '0);
    assign m_tdata  = TDATA_W'(skid_src_reg[rd_ptr_reg]);
    assign m_tuser  = skid_oor_reg[rd_ptr_reg];

    // A configuration write closes the input until the strides are rebuilt.
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted right after a configuration write");

    // An out-of-range result always carries a zero source index.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out-of-range result with nonzero source index");

    // The skid buffer never overfills.
    a_skid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_cnt_reg == SKID_CNT_W'(SKID_DEPTH)) |=>
            (skid_cnt_reg == SKID_CNT_W'(SKID_DEPTH)) || $past(pop))
        else $error("skid buffer count changed without a pop");

endmodule

// ----- bench/tensor_transpose_index_map_checker.sv -----
// Checker for the tensor transpose index map: follows register writes, predicts the
// source index of every accepted output index and compares it with the returned results.
// Depends on ttim_pkg.
module tensor_transpose_index_map_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ttim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttim_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ttim_pkg::TDATA_W-1:0]    s_tdata,  // [31:0] output_index
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ttim_pkg::TDATA_W-1:0]    m_tdata,  // [31:0] source_index
    input  logic                            m_tuser,  // [0] out_of_range
    output int unsigned                     mismatch_count,
    output int unsigned                     results_seen,
    output int unsigned                     pending,
    output logic [63:0]                     element_count
);
    import ttim_pkg::*;

    localparam logic [63:0] SPAN_LIMIT = 64'h1_0000_0000;

    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic             out_of_range;
    } mapped_index_t;

    typedef struct packed {
        logic [RANK_W-1:0]           used;
        logic [DIMS-1:0][DIM_W-1:0]  axis;
        logic [DIMS-1:0][63:0]       in_stride;
        logic [DIMS-1:0][63:0]       out_stride;
        logic [63:0]                 count;
    } shape_t;

    logic [RANK_W-1:0]           rank_q;
    logic [DIMS-1:0][SIZE_W-1:0] size_q;
    logic [PERM_W-1:0]           perm_q;
    shape_t                      shape_now;
    mapped_index_t               expected_sources[$];

    function automatic logic [63:0] cap_mul(input logic [63:0] a, input logic [63:0] b);
        if (a == 0 || b == 0)
            return 64'd0;
        if (a >= SPAN_LIMIT || b >= SPAN_LIMIT)
            return SPAN_LIMIT;
        if (a > SPAN_LIMIT / b)
            return SPAN_LIMIT;
        return a * b;
    endfunction

    function automatic shape_t derive_shape(input logic [RANK_W-1:0] rank_v,
                                            input logic [DIMS-1:0][SIZE_W-1:0] sizes,
                                            input logic [PERM_W-1:0] perm_v);
        shape_t      sh;
        int          r;
        int          i;
        int          p;
        logic [63:0] acc;
        sh = '0;
        r = rank_v;
        if (r < 1)
            r = 1;
        if (r > DIMS)
            r = DIMS;
        sh.used = RANK_W'(r);
        for (i = 0; i < r; i++)
        begin
            p = perm_v[DIM_W*i +: DIM_W];
            if (p >= r)
                p = r - 1;
            sh.axis[i] = DIM_W'(p);
        end
        acc = 64'd1;
        for (i = r - 1; i >= 0; i--)
        begin
            sh.in_stride[i] = acc;
            acc = cap_mul(acc, 64'(sizes[i]));
        end
        acc = 64'd1;
        for (i = r - 1; i >= 0; i--)
        begin
            sh.out_stride[i] = acc;
            acc = cap_mul(acc, 64'(sizes[sh.axis[i]]));
        end
        sh.count = acc;
        return sh;
    endfunction

    function automatic mapped_index_t map_index(input shape_t sh, input logic [IDX_W-1:0] idx);
        mapped_index_t res;
        logic [63:0]   rem;
        logic [63:0]   q;
        logic [63:0]   term;
        logic [63:0]   src;
        int            i;
        res = '0;
        if (64'(idx) >= sh.count)
        begin
            res.out_of_range = 1'b1;
            return res;
        end
        rem = 64'(idx);
        src = 64'd0;
        for (i = 0; i < sh.used; i++)
        begin
            q = (sh.out_stride[i] != 0) ? rem / sh.out_stride[i] : 64'd0;
            rem = rem - q * sh.out_stride[i];
            if (q == 0)
                term = 64'd0;
            else if (sh.in_stride[sh.axis[i]] >= SPAN_LIMIT || q >= SPAN_LIMIT)
                term = SPAN_LIMIT;
            else
                term = q * sh.in_stride[sh.axis[i]];
            if (term >= SPAN_LIMIT || src + term >= SPAN_LIMIT)
                src = SPAN_LIMIT - 1;
            else
                src = src + term;
        end
        res.source_index = src[IDX_W-1:0];
        return res;
    endfunction

    always_comb
    begin
        shape_now = derive_shape(rank_q, size_q, perm_q);
    end

    assign element_count = shape_now.count;

    always @(posedge clk or negedge rst_n)
    begin : watch
        mapped_index_t want;
        int unsigned   errs;
        if (!rst_n)
        begin
            rank_q         <= RANK_RESET;
            size_q         <= {DIMS{SIZE_RESET}};
            perm_q         <= PERM_RESET;
            mismatch_count <= 0;
            results_seen   <= 0;
            pending        <= 0;
            expected_sources.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RANK:  rank_q    <= cfg_data[RANK_W-1:0];
                    REG_SIZE0: size_q[0] <= cfg_data[SIZE_W-1:0];
                    REG_SIZE1: size_q[1] <= cfg_data[SIZE_W-1:0];
                    REG_SIZE2: size_q[2] <= cfg_data[SIZE_W-1:0];
                    REG_SIZE3: size_q[3] <= cfg_data[SIZE_W-1:0];
                    REG_PERM:  perm_q    <= cfg_data[PERM_W-1:0];
                    default:   ;
                endcase
            end
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                results_seen <= results_seen + 1;
                if (expected_sources.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, %s %h %s %b",
                             $time, "actual source_index", m_tdata[IDX_W-1:0],
                             "out_of_range", m_tuser);
                    errs++;
                end
                else
                begin
                    want = expected_sources.pop_front();
                    if (m_tdata[IDX_W-1:0] !== want.source_index)
                    begin
                        $display("%0t: source_index mismatch, expected %h, actual %h",
                                 $time, want.source_index, m_tdata[IDX_W-1:0]);
                        errs++;
                    end
                    if (m_tuser !== want.out_of_range)
                    begin
                        $display("%0t: out_of_range mismatch, expected %b, actual %b",
                                 $time, want.out_of_range, m_tuser);
                        errs++;
                    end
                end
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                expected_sources.insert(expected_sources.size(),
                                        map_index(shape_now, s_tdata[IDX_W-1:0]));
            mismatch_count <= mismatch_count + errs;
            pending <= expected_sources.size();
        end
    end

endmodule

// ----- bench/tensor_transpose_index_map_tb.sv -----
// Testbench top for the tensor transpose index map: clock, reset, register setup,
// output index stimulus with random stalls on both streams, and the final verdict.
// Depends on ttim_pkg, tensor_transpose_index_map and tensor_transpose_index_map_checker.
module tensor_transpose_index_map_tb;
    import ttim_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;
    localparam int IDLE_PCT = 25;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  steady = 1'b0;

    int unsigned items_sent = 0;
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned pending;
    logic [63:0] element_count;

    tensor_transpose_index_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tensor_transpose_index_map_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_seen   (results_seen),
        .pending        (pending),
        .element_count  (element_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The spare register write comes last, so the checker's shape is settled on return.
    task automatic load_shape(input logic [RANK_W-1:0] rank_v,
                              input logic [DIMS-1:0][SIZE_W-1:0] sizes,
                              input logic [PERM_W-1:0] perm_v);
        logic [CFG_DATA_W-1:0] noise;
        int                    d;
        noise = CFG_DATA_W'($urandom());
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_RANK;
        cfg_data  <= {noise[CFG_DATA_W-1:RANK_W], rank_v};
        @(posedge clk);
        for (d = 0; d < DIMS; d++)
        begin
            cfg_index <= CFG_IDX_W'(REG_SIZE0 + d);
            cfg_data  <= sizes[d];
            @(posedge clk);
        end
        cfg_index <= REG_PERM;
        cfg_data  <= {noise[CFG_DATA_W-1:PERM_W], perm_v};
        @(posedge clk);
        cfg_index <= noise[0] ? REG_SPARE0 : REG_SPARE1;
        cfg_data  <= CFG_DATA_W'($urandom());
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_index(input logic [IDX_W-1:0] idx);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'($urandom());
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(idx);
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_seen != items_sent);
    endtask

    initial
    begin : stimulus
        logic [DIMS-1:0][SIZE_W-1:0] sizes;
        logic [RANK_W-1:0]           rank_pick;
        logic [63:0]                 span;
        logic [63:0]                 near;
        logic [IDX_W-1:0]            idx;
        int                          ph;
        int                          k;
        int                          d;
        int                          sel;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_index(32'd0);
        send_index(32'd1);
        send_index(32'hFFFF_FFFF);
        drain();

        load_shape(3'd4, {16'd5, 16'd4, 16'd3, 16'd2}, 8'd228);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd59);
        send_index(32'd119);
        send_index(32'd120);
        drain();

        load_shape(3'd4, {16'd5, 16'd4, 16'd3, 16'd2}, 8'h1B);
        send_index(32'd0);
        send_index(32'd7);
        send_index(32'd118);
        send_index(32'd119);
        drain();

        load_shape(3'd2, {16'd9, 16'd7, 16'd5, 16'd3}, 8'hF1);
        send_index(32'd0);
        send_index(32'd6);
        send_index(32'd14);
        send_index(32'd15);
        drain();

        load_shape(3'd0, {16'd1, 16'd1, 16'd1, 16'hFFFF}, 8'hFF);
        send_index(32'd65534);
        send_index(32'd65535);
        drain();

        load_shape(3'd7, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 8'h00);
        send_index(32'hFFFF_FFFF);
        send_index(32'h0001_0000);
        send_index(32'hFFFE_0001);
        drain();

        load_shape(3'd4, {16'd3, 16'd0, 16'd2, 16'd2}, 8'd228);
        send_index(32'd0);
        send_index(32'd5);
        drain();

        load_shape(3'd1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1}, 8'd228);
        send_index(32'd0);
        send_index(32'd1);
        drain();

        for (ph = 0; ph < 14; ph++)
        begin
            steady <= (ph == 5);
            rank_pick = ($urandom_range(9) == 0) ? RANK_W'($urandom_range(7))
                                                  : RANK_W'($urandom_range(4, 1));
            for (d = 0; d < DIMS; d++)
            begin
                case ($urandom_range(19))
                    0:       sizes[d] = 16'd0;
                    1:       sizes[d] = 16'hFFFF;
                    2:       sizes[d] = SIZE_W'($urandom_range(65535, 1));
                    default: sizes[d] = SIZE_W'($urandom_range(12, 1));
                endcase
            end
            load_shape(rank_pick, sizes, PERM_W'($urandom()));
            span = element_count;
            for (k = 0; k < 50; k++)
            begin
                sel = $urandom_range(99);
                if (span == 0 || sel < 15)
                    idx = $urandom();
                else if (sel < 25)
                begin
                    near = span - 64'd1 + 64'($urandom_range(2));
                    idx = (near > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : near[IDX_W-1:0];
                end
                else
                    idx = $urandom_range(32'(span - 64'd1));
                send_index(idx);
            end
            drain();
        end

        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
